// ===== rtl/qjm_pkg.sv =====
// ----------------------------------------------------------------------------
// qjm_pkg: shared types and constants of the quintic joint move generator
// Holds the angle type, the fixed-point constants, and the command and status
// structures that join the controller and the datapath.
// ----------------------------------------------------------------------------
package qjm_pkg;

	localparam int NJ     = 7;
	localparam int JOINTS = 7;

	typedef logic signed [26:0] ang_t;
	typedef logic signed [27:0] diff_t;
	typedef logic [2:0]         idx_t;

	localparam logic [2:0]  REG_SPEED   = 3'd0;
	localparam logic [16:0] SPEED_RESET = 17'd13107;
	localparam logic [31:0] DUR_RESET   = 32'd1000000;
	localparam logic [31:0] MIN_DUR     = 32'd500000;
	localparam logic [19:0] US_PER_S    = 20'd1000000;
	localparam logic [16:0] Q_ONE       = 17'd65536;
	localparam logic [19:0] BLEND_A     = 20'd655360;
	localparam logic [19:0] BLEND_B     = 20'd983040;
	localparam logic [5:0]  DUR_ITERS   = 6'd48;
	localparam logic [5:0]  T_ITERS     = 6'd16;

	typedef enum logic [2:0] {
		MS_DUR,
		MS_T2,
		MS_T3,
		MS_INNER,
		MS_ALPHA,
		MS_JOINT
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     maxd_en;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     div_dur_go;
		logic     div_t_go;
		logic     dur_set;
		logic     elap_en;
		logic     t_set;
		logic     alpha_set;
		logic     joint_wr;
		logic     out_load;
		idx_t     idx;
	} ctl_t;

	typedef struct packed {
		logic div_done;
		logic started;
		logic out_busy;
	} sts_t;

endpackage

// ===== rtl/qjm_if.sv =====
// ----------------------------------------------------------------------------
// qjm_if: channel interfaces of the quintic joint move generator
// Tick request channel, command result channel and register write channel.
// ----------------------------------------------------------------------------
interface qjm_tick_if import qjm_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [15:0] period_us;
	ang_t        start_joint1;
	ang_t        start_joint2;
	ang_t        start_joint3;
	ang_t        start_joint4;
	ang_t        start_joint5;
	ang_t        start_joint6;
	ang_t        start_joint7;

	modport source (output valid, period_us, start_joint1, start_joint2, start_joint3,
		start_joint4, start_joint5, start_joint6, start_joint7, input ready);
	modport sink (input valid, period_us, start_joint1, start_joint2, start_joint3,
		start_joint4, start_joint5, start_joint6, start_joint7, output ready);
endinterface

interface qjm_cmd_if import qjm_pkg::*; ();
	logic valid;
	logic ready;
	ang_t cmd_joint1;
	ang_t cmd_joint2;
	ang_t cmd_joint3;
	ang_t cmd_joint4;
	ang_t cmd_joint5;
	ang_t cmd_joint6;
	ang_t cmd_joint7;
	logic finished;

	modport source (output valid, cmd_joint1, cmd_joint2, cmd_joint3, cmd_joint4,
		cmd_joint5, cmd_joint6, cmd_joint7, finished, input ready);
	modport sink (input valid, cmd_joint1, cmd_joint2, cmd_joint3, cmd_joint4,
		cmd_joint5, cmd_joint6, cmd_joint7, finished, output ready);
endinterface

interface qjm_cfg_if ();
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [26:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/quintic_joint_move_generator.sv =====
// ----------------------------------------------------------------------------
// quintic_joint_move_generator: seven-joint minimum-jerk move generator
// Produces one set of joint commands for every timing tick request.
// ----------------------------------------------------------------------------
// The tick channel carries the elapsed period in microseconds and the current
// joint angles, which are latched only by the first request after reset. That
// first request also fixes the move duration from the largest joint distance
// and the speed register. Each request returns one result on the cmd channel
// with the seven commanded angles and the finished flag.
// The cfg channel writes the speed register (index 0) and the goal angles
// (indexes 1 to 7); it is always ready and should be used only while idle.
// The first tick after reset also runs the joint distance scan, the duration
// product and the 48-step duration division. Every tick runs the 16-step
// time division and uses the single shared multiplier four times for the
// blend and once per joint. One tick is processed at a time, so a new tick
// is not taken while one is in progress; the next tick is taken as soon as
// the previous result sits in the output register. If the receiver stalls,
// the result is held and the next tick waits before its result is written.
// Reset clears the move state and restores the register defaults.
// ----------------------------------------------------------------------------
module quintic_joint_move_generator import qjm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	qjm_tick_if.sink  tick,
	qjm_cmd_if.source cmd,
	qjm_cfg_if.sink   cfg
);

	logic [16:0] speed_q;
	ang_t        goal_q [NJ];
	ang_t        start_in [NJ];
	ang_t        out_cmd [NJ];
	idx_t        goal_idx;
	ctl_t        ctl;
	sts_t        sts;

	assign cfg.ready = 1'b1;
	assign goal_idx  = cfg.index - 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPEED_RESET;
			for (int j = 0; j < NJ; j++) begin
				goal_q[j] <= '0;
			end
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SPEED: begin
					speed_q <= cfg.data[16:0];
				end
				default: begin
					goal_q[goal_idx] <= cfg.data;
				end
			endcase
		end
	end

	assign start_in[0] = tick.start_joint1;
	assign start_in[1] = tick.start_joint2;
	assign start_in[2] = tick.start_joint3;
	assign start_in[3] = tick.start_joint4;
	assign start_in[4] = tick.start_joint5;
	assign start_in[5] = tick.start_joint6;
	assign start_in[6] = tick.start_joint7;

	qjm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tick.valid),
		.in_ready (tick.ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	qjm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.period_in    (tick.period_us),
		.start_in     (start_in),
		.goal         (goal_q),
		.speed        (speed_q),
		.out_ready    (cmd.ready),
		.out_valid    (cmd.valid),
		.out_cmd      (out_cmd),
		.out_finished (cmd.finished)
	);

	assign cmd.cmd_joint1 = out_cmd[0];
	assign cmd.cmd_joint2 = out_cmd[1];
	assign cmd.cmd_joint3 = out_cmd[2];
	assign cmd.cmd_joint4 = out_cmd[3];
	assign cmd.cmd_joint5 = out_cmd[4];
	assign cmd.cmd_joint6 = out_cmd[5];
	assign cmd.cmd_joint7 = out_cmd[6];

endmodule

// ===== rtl/qjm_div.sv =====
// ----------------------------------------------------------------------------
// qjm_div: restoring divider, one quotient bit per cycle
// Runs a programmable number of steps from a given partial remainder.
// ----------------------------------------------------------------------------
module qjm_div import qjm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] rem0,
	input  logic [47:0] num,
	input  logic [31:0] dvs,
	input  logic [5:0]  iters,
	output logic        done,
	output logic [47:0] quot
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [5:0]  last_q;
	logic [31:0] rem_q;
	logic [47:0] num_q;
	logic [47:0] quot_q;
	logic [31:0] dvs_q;
	logic [32:0] sh;
	logic [32:0] sub;
	logic        ge;

	assign sh   = {rem_q, num_q[47]};
	assign sub  = sh - {1'b0, dvs_q};
	assign ge   = sh >= {1'b0, dvs_q};
	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == last_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= rem0;
			num_q  <= num;
			dvs_q  <= dvs;
			quot_q <= '0;
			last_q <= iters - 6'd1;
		end else if (busy_q) begin
			rem_q  <= ge ? sub[31:0] : sh[31:0];
			num_q  <= {num_q[46:0], 1'b0};
			quot_q <= {quot_q[46:0], ge};
		end
	end

endmodule

// ===== rtl/qjm_dp.sv =====
// ----------------------------------------------------------------------------
// qjm_dp: datapath of the quintic joint move generator
// Move state, shared multiplier, divider, blend evaluation and result register.
// ----------------------------------------------------------------------------
module qjm_dp import qjm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	output sts_t        sts,
	input  logic [15:0] period_in,
	input  ang_t        start_in [NJ],
	input  ang_t        goal [NJ],
	input  logic [16:0] speed,
	input  logic        out_ready,
	output logic        out_valid,
	output ang_t        out_cmd [NJ],
	output logic        out_finished
);

	ang_t               start_q [NJ];
	ang_t               cmd_q [NJ];
	ang_t               out_cmd_q [NJ];
	logic [15:0]        period_q;
	logic [27:0]        maxd_q;
	logic [31:0]        dur_q;
	logic [31:0]        elapsed_q;
	logic               started_q;
	logic               done_q;
	logic [16:0]        t_q;
	logic [16:0]        t3_q;
	logic [16:0]        alpha_q;
	logic signed [49:0] prod_q;
	logic               out_valid_q;
	logic               out_fin_q;

	idx_t               jsel;
	idx_t               wi;
	diff_t              diff;
	logic [27:0]        adiff;
	logic signed [28:0] ma;
	logic signed [20:0] mb;
	logic [19:0]        six_t;
	logic [19:0]        inner_b;
	logic [19:0]        v;
	logic [17:0]        s;
	logic               div_done;
	logic [47:0]        quot;
	logic [31:0]        dur_raw;
	logic [32:0]        sum;
	logic signed [49:0] shifted;
	logic [27:0]        cval;

	assign jsel    = (32'(ctl.idx) < NJ) ? ctl.idx : '0;
	assign wi      = ctl.idx - 3'd1;
	assign diff    = {goal[jsel][26], goal[jsel]} - {start_q[jsel][26], start_q[jsel]};
	assign adiff   = diff[27] ? 28'(-diff) : 28'(diff);
	assign six_t   = ({3'b0, t_q} << 2) + ({3'b0, t_q} << 1);
	assign inner_b = BLEND_B - six_t;
	assign v       = BLEND_A - prod_q[35:16];
	assign s       = (speed == '0) ? 18'd1 : {speed, 1'b0};
	assign dur_raw = (|quot[47:32]) ? 32'hFFFF_FFFF : quot[31:0];
	assign sum     = {1'b0, elapsed_q} + {17'b0, period_q};
	assign shifted = prod_q >>> 16;
	assign cval    = {start_q[wi][26], start_q[wi]} + shifted[27:0];

	always_comb begin
		case (ctl.mul_sel)
			MS_T2: begin
				ma = {12'b0, t_q};
				mb = {4'b0, t_q};
			end
			MS_T3: begin
				ma = {12'b0, prod_q[32:16]};
				mb = {4'b0, t_q};
			end
			MS_INNER: begin
				ma = {12'b0, t_q};
				mb = {1'b0, inner_b};
			end
			MS_ALPHA: begin
				ma = {12'b0, t3_q};
				mb = {1'b0, v};
			end
			MS_JOINT: begin
				ma = {diff[27], diff};
				mb = {4'b0, alpha_q};
			end
			default: begin
				ma = {1'b0, maxd_q};
				mb = {1'b0, US_PER_S};
			end
		endcase
	end

	qjm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (ctl.div_dur_go | ctl.div_t_go),
		.rem0   (ctl.div_dur_go ? 32'd0 : elapsed_q),
		.num    (ctl.div_dur_go ? prod_q[47:0] : 48'd0),
		.dvs    (ctl.div_dur_go ? {6'b0, s, 8'b0} : dur_q),
		.iters  (ctl.div_dur_go ? DUR_ITERS : T_ITERS),
		.done   (div_done),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			done_q      <= 1'b0;
			elapsed_q   <= '0;
			dur_q       <= DUR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.dur_set) begin
				started_q <= 1'b1;
				dur_q     <= (dur_raw < MIN_DUR) ? MIN_DUR : dur_raw;
			end
			if (ctl.elap_en) begin
				elapsed_q <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			end
			if (ctl.t_set && (elapsed_q >= dur_q)) begin
				done_q <= 1'b1;
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			period_q <= period_in;
			maxd_q   <= '0;
			if (!started_q) begin
				start_q <= start_in;
			end
		end
		if (ctl.maxd_en && (adiff > maxd_q)) begin
			maxd_q <= adiff;
		end
		if (ctl.mul_en) begin
			prod_q <= ma * mb;
		end
		if (ctl.mul_en && (ctl.mul_sel == MS_INNER)) begin
			t3_q <= prod_q[32:16];
		end
		if (ctl.t_set) begin
			t_q <= (elapsed_q >= dur_q) ? Q_ONE : {1'b0, quot[15:0]};
		end
		if (ctl.alpha_set) begin
			alpha_q <= (prod_q[36:16] > {4'b0, Q_ONE}) ? Q_ONE : prod_q[32:16];
		end
		if (ctl.joint_wr) begin
			if (32'(wi) >= JOINTS) begin
				cmd_q[wi] <= '0;
			end else if (done_q) begin
				cmd_q[wi] <= goal[wi];
			end else begin
				cmd_q[wi] <= cval[26:0];
			end
		end
		if (ctl.out_load) begin
			out_cmd_q <= cmd_q;
			out_fin_q <= done_q;
		end
	end

	assign sts.div_done  = div_done;
	assign sts.started   = started_q;
	assign sts.out_busy  = out_valid_q & ~out_ready;
	assign out_valid     = out_valid_q;
	assign out_cmd       = out_cmd_q;
	assign out_finished  = out_fin_q;

endmodule

// ===== rtl/qjm_ctrl.sv =====
// ----------------------------------------------------------------------------
// qjm_ctrl: sequencer of the quintic joint move generator
// Steps the datapath through duration setup, time scaling, blend and joints.
// ----------------------------------------------------------------------------
module qjm_ctrl import qjm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output ctl_t ctl
);

	typedef enum logic [16:0] {
		S_IDLE  = 17'b00000000000000001,
		S_MAXD  = 17'b00000000000000010,
		S_DMUL  = 17'b00000000000000100,
		S_DGO   = 17'b00000000000001000,
		S_DWAIT = 17'b00000000000010000,
		S_DSET  = 17'b00000000000100000,
		S_ELAP  = 17'b00000000001000000,
		S_TGO   = 17'b00000000010000000,
		S_TWAIT = 17'b00000000100000000,
		S_TSET  = 17'b00000001000000000,
		S_T2    = 17'b00000010000000000,
		S_T3    = 17'b00000100000000000,
		S_INNER = 17'b00001000000000000,
		S_ALPHA = 17'b00010000000000000,
		S_ASAT  = 17'b00100000000000000,
		S_JOINT = 17'b01000000000000000,
		S_OUT   = 17'b10000000000000000
	} state_t;

	state_t state_q;
	state_t state_d;
	idx_t   idx_q;
	idx_t   idx_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		ctl     = '0;
		ctl.idx = idx_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					idx_d    = '0;
					state_d  = sts.started ? S_ELAP : S_MAXD;
				end
			end
			S_MAXD: begin
				ctl.maxd_en = 1'b1;
				idx_d       = idx_q + 3'd1;
				if (32'(idx_q) == JOINTS - 1) begin
					state_d = S_DMUL;
				end
			end
			S_DMUL: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MS_DUR;
				state_d     = S_DGO;
			end
			S_DGO: begin
				ctl.div_dur_go = 1'b1;
				state_d        = S_DWAIT;
			end
			S_DWAIT: begin
				if (sts.div_done) begin
					state_d = S_DSET;
				end
			end
			S_DSET: begin
				ctl.dur_set = 1'b1;
				state_d     = S_ELAP;
			end
			S_ELAP: begin
				ctl.elap_en = 1'b1;
				state_d     = S_TGO;
			end
			S_TGO: begin
				ctl.div_t_go = 1'b1;
				state_d      = S_TWAIT;
			end
			S_TWAIT: begin
				if (sts.div_done) begin
					state_d = S_TSET;
				end
			end
			S_TSET: begin
				ctl.t_set = 1'b1;
				state_d   = S_T2;
			end
			S_T2: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MS_T2;
				state_d     = S_T3;
			end
			S_T3: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MS_T3;
				state_d     = S_INNER;
			end
			S_INNER: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MS_INNER;
				state_d     = S_ALPHA;
			end
			S_ALPHA: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MS_ALPHA;
				state_d     = S_ASAT;
			end
			S_ASAT: begin
				ctl.alpha_set = 1'b1;
				idx_d         = '0;
				state_d       = S_JOINT;
			end
			S_JOINT: begin
				ctl.mul_sel  = MS_JOINT;
				ctl.mul_en   = (32'(idx_q) < NJ);
				ctl.joint_wr = (idx_q != '0);
				idx_d        = idx_q + 3'd1;
				if (32'(idx_q) == NJ) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!sts.out_busy) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

endmodule

// ===== rtl/qjm_chk.sv =====
// ----------------------------------------------------------------------------
// qjm_chk: port checks of the quintic joint move generator
// Watches the tick and command channels and is bound to the top level.
// ----------------------------------------------------------------------------
module qjm_chk (
	input logic clk,
	input logic arst_n,
	input logic tick_valid,
	input logic tick_ready,
	input logic cmd_valid,
	input logic cmd_ready
);

	// A stalled result stays offered.
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid)
		else $error("command withdrawn while stalled");

	// A tick request is worked on before the next is taken, so none follows at once.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready |=> !tick_ready)
		else $error("tick accepted in back-to-back cycles");

	// The handshake outputs are always driven to known levels out of reset.
	a_hs_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({tick_ready, cmd_valid}))
		else $error("handshake output unknown");

endmodule

bind quintic_joint_move_generator qjm_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.tick_valid (tick.valid),
	.tick_ready (tick.ready),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready)
);
